// ===== sv/assert_macros.svh =====
// Assertion macros shared by the search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dfs_pkg.sv =====
// Types, constants and helper functions of the depth-first search block.
`timescale 1ns / 1ps
package dfs_pkg;

  localparam int VERT_W           = 4;
  localparam int ROW_W            = 16;
  localparam int MAX_VERT         = 16;
  localparam int NUM_VERTICES_DEF = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [VERT_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic [VERT_W-1:0] start_vertex;
  } cmd_t;

  typedef struct packed {
    logic [VERT_W-1:0] vertex;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [VERT_W-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic [VERT_W-1:0] raddr;
  } adj_req_t;

  typedef struct packed {
    logic              we;
    logic [VERT_W-1:0] waddr;
    logic [VERT_W-1:0] wdata;
    logic [VERT_W-1:0] raddr;
  } stk_req_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [VERT_W-1:0] lowest_set(input logic [ROW_W-1:0] c);
    logic [VERT_W-1:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (c[i]) r = VERT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== sv/dfs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module dfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dfs_core.sv =====
// Search sequencer: visited set, stack pointer, pending result and control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfs_core import dfs_pkg::*; #(
  parameter int NV = NUM_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             valid,
  output res_t             result,
  output adj_req_t         adj_req,
  input  logic [ROW_W-1:0] adj_rdata,
  output stk_req_t         stk_req,
  input  logic [VERT_W-1:0] stk_rdata
);

  localparam int DW = $clog2(NV + 1);
  localparam logic [ROW_W-1:0] VMASK = ROW_W'((64'd1 << NV) - 64'd1);

  typedef enum logic [1:0] {S_IDLE, S_ADJ, S_EVAL, S_POP} state_t;

  state_t            state;
  logic [ROW_W-1:0]  visited;
  logic [DW-1:0]     depth;
  logic [VERT_W-1:0] top;
  logic [VERT_W-1:0] pend;

  logic              accept;
  logic              in_range_row;
  logic              in_range_start;
  logic [ROW_W-1:0]  cand;
  logic [VERT_W-1:0] nb;
  logic [DW-1:0]     depth_m2;

  assign busy           = (state != S_IDLE);
  assign accept         = start && !busy;
  assign in_range_row   = {1'b0, cmd.row_index} < (VERT_W + 1)'(NV);
  assign in_range_start = {1'b0, cmd.start_vertex} < (VERT_W + 1)'(NV);
  assign cand           = adj_rdata & VMASK & ~visited;
  assign nb             = lowest_set(cand);
  assign depth_m2       = depth - DW'(2);

  always_comb begin
    adj_req.we    = accept && (cmd.opcode == OP_LOAD) && in_range_row;
    adj_req.waddr = cmd.row_index;
    adj_req.wdata = cmd.row_bits;
    adj_req.raddr = (state == S_POP) ? stk_rdata : top;

    stk_req.we    = '0;
    stk_req.waddr = VERT_W'(depth);
    stk_req.wdata = nb;
    stk_req.raddr = VERT_W'(depth_m2);
    if (accept && (cmd.opcode == OP_RUN) && in_range_start) begin
      stk_req.we    = 1'b1;
      stk_req.waddr = '0;
      stk_req.wdata = cmd.start_vertex;
    end else if (state == S_EVAL && cand != '0) begin
      stk_req.we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      visited <= '0;
      depth   <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && cmd.opcode == OP_RUN) begin
            visited <= '0;
            depth   <= '0;
            if (in_range_start) begin
              visited <= ROW_W'(1) << cmd.start_vertex;
              depth   <= DW'(1);
              top     <= cmd.start_vertex;
              pend    <= cmd.start_vertex;
              state   <= S_ADJ;
            end
          end
        end
        S_ADJ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cand != '0) begin
            visited       <= visited | (ROW_W'(1) << nb);
            depth         <= depth + DW'(1);
            top           <= nb;
            pend          <= nb;
            valid         <= 1'b1;
            result.vertex <= pend;
            result.last   <= 1'b0;
            state         <= S_ADJ;
          end else begin
            depth <= depth - DW'(1);
            if (depth == DW'(1)) begin
              valid         <= 1'b1;
              result.vertex <= pend;
              result.last   <= 1'b1;
              state         <= S_IDLE;
            end else begin
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          top   <= stk_rdata;
          state <= S_EVAL;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_depth_bound, clk, rst, depth <= DW'(NV), "stack deeper than vertex count")
  `ASSERT_IMPL(a_eval_nonempty, clk, rst, state == S_EVAL, depth != '0, "evaluation with empty stack")
  `ASSERT_IMPL(a_push_unvisited, clk, rst, state == S_EVAL && cand != '0, !visited[nb], "pushed a visited vertex")
  `ASSERT_IMPL(a_last_idle, clk, rst, valid && result.last, state == S_IDLE, "final beat while still searching")

endmodule

// ===== sv/dfs_visit_order_adjacency_matrix.sv =====
// Top level of the depth-first search block: adjacency and stack memories and the sequencer.
`timescale 1ns / 1ps
// Depth-first visit order over a graph of up to sixteen vertices. A command beat is
// taken when start is high and busy is low. A load beat (opcode zero) writes one row
// of the adjacency matrix and gives no result; a load to a row at or
// above the vertex count is dropped. A run beat (opcode one) clears the visited set
// and walks the graph from start_vertex, always following the lowest-numbered
// unvisited neighbour of the vertex on top of the stack. Each visited vertex appears
// on result for exactly one cycle with valid high, the start vertex first, and the
// final one carries last; the receiver cannot hold results back, so they must be
// taken as they come. A run from a vertex at or above the vertex count gives no
// result. Every row that a run can reach must have been loaded beforehand. A run
// takes, per vertex pushed, an adjacency memory read and then the neighbour choice,
// and per pop a stack memory read followed by the adjacency read, while the final
// pop reads no memory; the final beat appears in the same cycle in which busy
// falls. Each result beat is emitted when the next vertex is found, or when the
// stack empties for the final one, because last is only known then. The adjacency
// matrix and the stack hold no reset values; the visited set and stack depth live
// in registers.
module dfs_visit_order_adjacency_matrix import dfs_pkg::*; #(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic valid,
  output res_t result
);

  // Only sixteen vertices are addressable by the four-bit fields.
  localparam int NV = (NUM_VERTICES < MAX_VERT) ? NUM_VERTICES : MAX_VERT;
  localparam int AW = $clog2(NV);

  adj_req_t          adj_req;
  stk_req_t          stk_req;
  logic [ROW_W-1:0]  adj_rdata;
  logic [VERT_W-1:0] stk_rdata;

  dfs_core #(.NV(NV)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .valid     (valid),
    .result    (result),
    .adj_req   (adj_req),
    .adj_rdata (adj_rdata),
    .stk_req   (stk_req),
    .stk_rdata (stk_rdata)
  );

  // One row of ROW_W edge bits per vertex.
  dfs_ram #(.WIDTH(ROW_W), .DEPTH(NV)) u_adj_ram (
    .clk   (clk),
    .we    (adj_req.we),
    .waddr (adj_req.waddr[AW-1:0]),
    .wdata (adj_req.wdata),
    .raddr (adj_req.raddr[AW-1:0]),
    .rdata (adj_rdata)
  );

  // Path stack; every vertex is pushed at most once, so NV entries suffice.
  dfs_ram #(.WIDTH(VERT_W), .DEPTH(NV)) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr[AW-1:0]),
    .wdata (stk_req.wdata),
    .raddr (stk_req.raddr[AW-1:0]),
    .rdata (stk_rdata)
  );

endmodule
